### rtl/core/vn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vn_pkg;

    localparam int NUM_COMPS   = 4;
    localparam int DEF_MAX_DIM = 4;
    localparam int DIM_W       = 3;
    localparam int COMP_W      = 32;
    localparam int LEN_W       = 33;
    localparam int UNIT_W      = 32;
    localparam int SUM_W       = 65;
    localparam int SQRT_STEPS  = 32;
    localparam int SQRT_REM_W  = 35;
    localparam int DIV_STEPS   = 31;
    localparam int DIV_REM_W   = 34;
    localparam logic [DIM_W-1:0] DIM_RESET = 3'd3;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp0;
        logic signed [COMP_W-1:0] comp1;
        logic signed [COMP_W-1:0] comp2;
        logic signed [COMP_W-1:0] comp3;
    } t_vn_in;

    typedef struct packed {
        logic        [LEN_W-1:0]  length;
        logic signed [UNIT_W-1:0] unit0;
        logic signed [UNIT_W-1:0] unit1;
        logic signed [UNIT_W-1:0] unit2;
        logic signed [UNIT_W-1:0] unit3;
        logic                     zero_length;
    } t_vn_out;

    typedef struct packed {
        logic [NUM_COMPS-1:0][COMP_W-1:0] mag;
        logic [NUM_COMPS-1:0]             neg;
    } t_vn_side;

endpackage

`default_nettype wire

### rtl/core/vn_square.sv
`timescale 1ns / 1ps
`default_nettype none

module vn_square (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire vn_pkg::t_vn_in          i_in,
    input  wire [vn_pkg::DIM_W-1:0]      i_dim,
    output logic                         o_valid,
    output vn_pkg::t_vn_side             o_side,
    output logic [vn_pkg::SUM_W-1:0]     o_sum
);
    import vn_pkg::*;

    logic [NUM_COMPS-1:0][COMP_W-1:0] comps;
    t_vn_side                         n_a_side;
    logic                             r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    t_vn_side                         r_a_side, r_b_side, r_c_side, r_d_side;
    logic [NUM_COMPS-1:0][63:0]       r_b_sq;
    logic [SUM_W-1:0]                 r_c_lo, r_c_hi, r_d_sum;

    assign comps[0] = i_in.comp0;
    assign comps[1] = i_in.comp1;
    assign comps[2] = i_in.comp2;
    assign comps[3] = i_in.comp3;

    always_comb begin
        for (int i = 0; i < NUM_COMPS; i++) begin
            if (DIM_W'(i) < i_dim) begin
                n_a_side.neg[i] = comps[i][COMP_W-1];
                n_a_side.mag[i] = comps[i][COMP_W-1] ? (~comps[i] + 32'd1) : comps[i];
            end else begin
                n_a_side.neg[i] = 1'b0;
                n_a_side.mag[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_side <= n_a_side;
        r_b_side <= r_a_side;
        for (int i = 0; i < NUM_COMPS; i++) begin
            r_b_sq[i] <= 64'(r_a_side.mag[i]) * 64'(r_a_side.mag[i]);
        end
        r_c_side <= r_b_side;
        r_c_lo   <= SUM_W'(r_b_sq[0]) + SUM_W'(r_b_sq[1]);
        r_c_hi   <= SUM_W'(r_b_sq[2]) + SUM_W'(r_b_sq[3]);
        r_d_side <= r_c_side;
        r_d_sum  <= r_c_lo + r_c_hi;
    end

    assign o_valid = r_d_valid;
    assign o_side  = r_d_side;
    assign o_sum   = r_d_sum;

endmodule

`default_nettype wire

### rtl/core/vn_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module vn_sqrt (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire vn_pkg::t_vn_side        i_side,
    input  wire [vn_pkg::SUM_W-1:0]      i_sum,
    output logic                         o_valid,
    output vn_pkg::t_vn_side             o_side,
    output logic [vn_pkg::LEN_W-1:0]     o_len
);
    import vn_pkg::*;

    logic                  w_valid [0:SQRT_STEPS];
    t_vn_side              w_side  [0:SQRT_STEPS];
    logic [63:0]           w_x     [0:SQRT_STEPS];
    logic [SQRT_REM_W-1:0] w_rem   [0:SQRT_STEPS];
    logic [31:0]           w_root  [0:SQRT_STEPS];
    logic                  w_big   [0:SQRT_STEPS];

    assign w_valid[0] = i_valid;
    assign w_side[0]  = i_side;
    assign w_x[0]     = i_sum[63:0];
    assign w_rem[0]   = '0;
    assign w_root[0]  = '0;
    assign w_big[0]   = i_sum[64];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [SQRT_REM_W-1:0] rem_sh;
        logic [SQRT_REM_W-1:0] trial;
        logic                  ge;
        logic                  r_valid;
        t_vn_side              r_side;
        logic [63:0]           r_x;
        logic [SQRT_REM_W-1:0] r_rem;
        logic [31:0]           r_root;
        logic                  r_big;

        always_comb begin
            rem_sh = {w_rem[k][SQRT_REM_W-3:0], w_x[k][63:62]};
            trial  = SQRT_REM_W'({w_root[k], 2'b01});
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else begin
                r_valid <= w_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_side <= w_side[k];
            r_x    <= {w_x[k][61:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {w_root[k][30:0], ge};
            r_big  <= w_big[k];
        end

        assign w_valid[k+1] = r_valid;
        assign w_side[k+1]  = r_side;
        assign w_x[k+1]     = r_x;
        assign w_rem[k+1]   = r_rem;
        assign w_root[k+1]  = r_root;
        assign w_big[k+1]   = r_big;
    end

    assign o_valid = w_valid[SQRT_STEPS];
    assign o_side  = w_side[SQRT_STEPS];
    assign o_len   = w_big[SQRT_STEPS] ? {1'b1, 32'd0} : {1'b0, w_root[SQRT_STEPS]};

endmodule

`default_nettype wire

### rtl/core/vn_div.sv
`timescale 1ns / 1ps
`default_nettype none

module vn_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire vn_pkg::t_vn_side        i_side,
    input  wire [vn_pkg::LEN_W-1:0]      i_len,
    output logic                         o_valid,
    output vn_pkg::t_vn_out              o_result
);
    import vn_pkg::*;

    logic                                w_valid [0:DIV_STEPS];
    logic [LEN_W-1:0]                    w_len   [0:DIV_STEPS];
    logic [NUM_COMPS-1:0]                w_neg   [0:DIV_STEPS];
    logic [NUM_COMPS-1:0]                w_low   [0:DIV_STEPS];
    logic [NUM_COMPS-1:0][DIV_REM_W-1:0] w_rem   [0:DIV_STEPS];
    logic [NUM_COMPS-1:0][DIV_STEPS-1:0] w_q     [0:DIV_STEPS];

    logic                                r_out_valid;
    t_vn_out                             r_out;
    logic [NUM_COMPS-1:0][UNIT_W-1:0]    n_units;
    logic                                n_zero;

    assign w_valid[0] = i_valid;
    assign w_len[0]   = i_len;
    assign w_neg[0]   = i_side.neg;

    for (genvar l = 0; l < NUM_COMPS; l++) begin : g_init
        assign w_low[0][l] = i_side.mag[l][0];
        assign w_rem[0][l] = DIV_REM_W'(i_side.mag[l][COMP_W-1:1]);
        assign w_q[0][l]   = '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [NUM_COMPS-1:0][DIV_REM_W-1:0] rem_sh;
        logic [NUM_COMPS-1:0]                ge;
        logic                                r_valid;
        logic [LEN_W-1:0]                    r_len;
        logic [NUM_COMPS-1:0]                r_neg;
        logic [NUM_COMPS-1:0][DIV_REM_W-1:0] r_rem;
        logic [NUM_COMPS-1:0][DIV_STEPS-1:0] r_q;

        always_comb begin
            for (int l = 0; l < NUM_COMPS; l++) begin
                rem_sh[l] = {w_rem[k][l][DIV_REM_W-2:0], (k == 0) ? w_low[k][l] : 1'b0};
                ge[l]     = (rem_sh[l] >= DIV_REM_W'(w_len[k]));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else begin
                r_valid <= w_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_len <= w_len[k];
            r_neg <= w_neg[k];
            for (int l = 0; l < NUM_COMPS; l++) begin
                r_rem[l] <= ge[l] ? (rem_sh[l] - DIV_REM_W'(w_len[k])) : rem_sh[l];
                r_q[l]   <= {w_q[k][l][DIV_STEPS-2:0], ge[l]};
            end
        end

        assign w_valid[k+1] = r_valid;
        assign w_len[k+1]   = r_len;
        assign w_neg[k+1]   = r_neg;
        assign w_low[k+1]   = '0;
        assign w_rem[k+1]   = r_rem;
        assign w_q[k+1]     = r_q;
    end

    always_comb begin
        n_zero = (w_len[DIV_STEPS] == '0);
        for (int l = 0; l < NUM_COMPS; l++) begin
            if (n_zero) begin
                n_units[l] = '0;
            end else if (w_neg[DIV_STEPS][l]) begin
                n_units[l] = ~UNIT_W'(w_q[DIV_STEPS][l]) + 32'd1;
            end else begin
                n_units[l] = UNIT_W'(w_q[DIV_STEPS][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.length      <= w_len[DIV_STEPS];
        r_out.unit0       <= n_units[0];
        r_out.unit1       <= n_units[1];
        r_out.unit2       <= n_units[2];
        r_out.unit3       <= n_units[3];
        r_out.zero_length <= n_zero;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

### rtl/core/vector_normalize.sv
`timescale 1ns / 1ps
`default_nettype none

// Vector normalizer: Euclidean length and unit vector of up to four Q16.16 components.
// A vector beat is taken at each clock edge where start is high and busy is low.
// Busy never rises, so a new vector may be started in every cycle.
// The result (length, unit components and zero-length flag) appears on o_result
// for exactly one cycle with o_valid high.
// The pipeline is made of the magnitude, squaring and summing stages, the
// one-bit-per-stage square root, the one-bit-per-stage dividers
// (one per component) and one output register.
// Results leave in the order vectors entered, one per vector; the receiver must
// take each beat when it is shown, since there is no back pressure on the output.
// The dimension register is written over its own valid/ready channel, which is
// always ready; write it only while no vector is in flight.
// Synchronous reset empties the pipeline and sets the dimension to three.
module vector_normalize #(
    parameter int MAX_DIM = vn_pkg::DEF_MAX_DIM
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire vn_pkg::t_vn_in          i_in,
    output logic                         o_valid,
    output vn_pkg::t_vn_out              o_result,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [vn_pkg::DIM_W-1:0]      i_cfg_data
);
    import vn_pkg::*;

    logic [DIM_W-1:0] r_dim;
    logic [DIM_W-1:0] eff_dim;
    logic             in_valid;
    logic             sq_valid, rt_valid;
    t_vn_side         sq_side, rt_side;
    logic [SUM_W-1:0] sq_sum;
    logic [LEN_W-1:0] rt_len;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign in_valid    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dim <= i_cfg_data;
        end
    end

    always_comb begin
        if (4'(r_dim) > 4'(MAX_DIM)) begin
            eff_dim = DIM_W'(MAX_DIM);
        end else begin
            eff_dim = r_dim;
        end
        if (4'(eff_dim) > 4'(NUM_COMPS)) begin
            eff_dim = DIM_W'(NUM_COMPS);
        end
    end

    vn_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_in    (i_in),
        .i_dim   (eff_dim),
        .o_valid (sq_valid),
        .o_side  (sq_side),
        .o_sum   (sq_sum)
    );

    vn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_side  (sq_side),
        .i_sum   (sq_sum),
        .o_valid (rt_valid),
        .o_side  (rt_side),
        .o_len   (rt_len)
    );

    vn_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (rt_valid),
        .i_side   (rt_side),
        .i_len    (rt_len),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

### tb/tb_vector_normalize.sv
`timescale 1ns / 1ps

module tb_vector_normalize;
    import vn_pkg::*;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    t_vn_in        i_in = '0;
    logic          o_valid;
    t_vn_out       o_result;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [DIM_W-1:0] i_cfg_data = '0;

    localparam int LATENCY = 68;

    vector_normalize i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    t_vn_out      pending_norms[$];
    logic [DIM_W-1:0] dim_reg;
    int           error_count = 0;
    int           vectors_sent = 0;
    int           results_seen = 0;
    int           zero_seen = 0;
    bit           gaps_on = 1'b1;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_vn_out normalize_vector(input t_vn_in v, input logic [DIM_W-1:0] d);
        logic signed [COMP_W-1:0] c[4];
        logic [32:0]  m;
        logic [64:0]  acc;
        logic [63:0]  len;
        logic [63:0]  q;
        logic [31:0]  u[4];
        int           dim;
        t_vn_out      r;
        c[0] = v.comp0; c[1] = v.comp1; c[2] = v.comp2; c[3] = v.comp3;
        dim = d;
        if (dim > NUM_COMPS) dim = NUM_COMPS;
        acc = '0;
        for (int k = 0; k < dim; k++) begin
            m = c[k][31] ? 33'(-{c[k][31], c[k]}) : {1'b0, c[k]};
            acc = acc + 65'(m) * 65'(m);
        end
        len = acc[64] ? 64'd1 << 32 : int_sqrt(acc[63:0]);
        for (int k = 0; k < 4; k++) begin
            u[k] = '0;
            if (k < dim && len != 0) begin
                m = c[k][31] ? 33'(-{c[k][31], c[k]}) : {1'b0, c[k]};
                q = ({31'd0, m} << 30) / len;
                if (c[k][31]) q = -q;
                u[k] = q[31:0];
            end
        end
        r.length = len[32:0];
        r.unit0 = u[0]; r.unit1 = u[1]; r.unit2 = u[2]; r.unit3 = u[3];
        r.zero_length = (len == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [32:0] got,
                                   input logic [32:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_vn_out e;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_norms.size() == 0) begin
                report_mismatch("unexpected beat", o_result.length, '0);
            end else begin
                e = pending_norms.pop_front();
                if (e.zero_length) zero_seen++;
                if (o_result.length !== e.length)
                    report_mismatch("length", o_result.length, e.length);
                if (o_result.unit0 !== e.unit0)
                    report_mismatch("unit0", 33'(o_result.unit0), 33'(e.unit0));
                if (o_result.unit1 !== e.unit1)
                    report_mismatch("unit1", 33'(o_result.unit1), 33'(e.unit1));
                if (o_result.unit2 !== e.unit2)
                    report_mismatch("unit2", 33'(o_result.unit2), 33'(e.unit2));
                if (o_result.unit3 !== e.unit3)
                    report_mismatch("unit3", 33'(o_result.unit3), 33'(e.unit3));
                if (o_result.zero_length !== e.zero_length)
                    report_mismatch("zero_length", 33'(o_result.zero_length),
                                    33'(e.zero_length));
            end
        end
    end

    task automatic send_vector(input t_vn_in v);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_norms.push_back(normalize_vector(v, dim_reg));
        vectors_sent++;
    endtask

    task automatic drain_pipeline();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_norms.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_dim(input logic [DIM_W-1:0] d);
        drain_pipeline();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        dim_reg = d;
    endtask

    function automatic logic [31:0] random_comp();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 8)) - 4);
            3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_vn_in random_vector();
        t_vn_in v;
        v.comp0 = random_comp(); v.comp1 = random_comp();
        v.comp2 = random_comp(); v.comp3 = random_comp();
        return v;
    endfunction

    task automatic test_directed();
        t_vn_in v;
        for (int d = 0; d < 8; d += 2) begin
            write_dim(DIM_W'(d == 6 ? 7 : d));
            v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            send_vector(v);
            v = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
            send_vector(v);
            send_vector('0);
            v = '{32'h0001_0000, 32'hffff_0000, 32'd0, 32'd1};
            send_vector(v);
            v = '{32'd0, 32'd0, 32'd0, 32'h8000_0000};
            send_vector(v);
        end
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) write_dim(DIM_W'($urandom_range(0, 7)));
            send_vector(random_vector());
        end
    endtask

    task automatic test_back_to_back(input int count);
        gaps_on = 1'b0;
        write_dim(3'd4);
        for (int n = 0; n < count; n++) send_vector(random_vector());
    endtask

    initial begin
        dim_reg = DIM_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_vector('{32'h0003_0000, 32'h0004_0000, 32'd0, 32'h7fff_ffff});
        test_directed();
        test_random(450);
        test_back_to_back(80);
        drain_pipeline();
        $display("Sent %0d vectors, checked %0d results (%0d with zero length),",
                 vectors_sent, results_seen, zero_seen);
        $display("over dimensions 0 to 7 including full-scale components.");
        if (error_count == 0 && pending_norms.size() == 0) begin
            $display("** vector_normalize: PASSED **");
        end else begin
            $display("** vector_normalize: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("** vector_normalize: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/core/vn_pkg.sv
rtl/core/vn_square.sv
rtl/core/vn_sqrt.sv
rtl/core/vn_div.sv
rtl/core/vector_normalize.sv
tb/tb_vector_normalize.sv
